FILE: design/ngfm_pkg.sv
// shared constants, widths and control types for the note gain fade mixer
// no dependencies
package ngfm_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MIX_WIDTH    = 24;

  localparam int REG_W     = 24;
  localparam int GAIN_W    = 16;
  localparam int IDX_W     = 2;
  localparam int FRAME_W   = 25;
  localparam int FRAC_BITS = 12;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(4096);

  localparam logic [IDX_W-1:0] REG_NOTE_OFFSET = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_NOTE_LENGTH = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_GAIN        = IDX_W'(2);

  // decay start: floor(L*17/4) times ceil(2^30/5), shifted down by 30
  localparam int             LEN17_W      = REG_W + 5;
  localparam int             V_W          = REG_W + 3;
  localparam int             RECIP_W      = 28;
  localparam int             RECIP_SHIFT  = 30;
  localparam logic [RECIP_W-1:0] RECIP_5  = RECIP_W'(214748365);
  localparam int             START_PROD_W = V_W + RECIP_W;

  // magnitude times gain, fade length, quotient width of the fade division
  localparam int PROD_W   = SAMPLE_WIDTH + 15;
  localparam int DLEN_W   = 22;
  localparam int QUO_W    = SAMPLE_WIDTH + 3;
  localparam int SCALED_W = PROD_W + DLEN_W;
  localparam int STEP_W   = $clog2(QUO_W);
  localparam int SUM_W    = ((MIX_WIDTH > SAMPLE_WIDTH + 4) ? MIX_WIDTH : SAMPLE_WIDTH + 4) + 1;

  typedef struct packed {
    logic accept;
    logic mul;
    logic eval;
    logic scale;
    logic div_step;
    logic write_out;
  } cmd_t;

  typedef struct packed {
    logic past;
    logic decay;
    logic out_free;
  } status_t;

endpackage

FILE: design/ngfm_ctrl.sv
// controller state machine: sequences multiply, evaluate, scale, divide, sum
// depends on ngfm_pkg
module ngfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ngfm_pkg::status_t status_i,
  output logic              in_ready_o,
  output ngfm_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_SCALE,
    ST_DIV,
    ST_SUM
  } state_e;

  state_e                          state_q, state_d;
  logic [ngfm_pkg::STEP_W-1:0]     step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.past) begin
          state_d = ST_IDLE;
        end else if (status_i.decay) begin
          state_d = ST_SCALE;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        step_d      = ngfm_pkg::STEP_W'(ngfm_pkg::QUO_W - 1);
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_SUM;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_SUM: begin
        if (status_i.out_free) begin
          cmd_o.write_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: design/ngfm_dp.sv
// datapath: registers, counter, gain and fade multipliers, serial divider,
// saturating sum and output register; depends on ngfm_pkg
module ngfm_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ngfm_pkg::cmd_t                        cmd_i,
  output ngfm_pkg::status_t                     status_o,
  input  logic                                  cfg_valid_i,
  input  logic [ngfm_pkg::IDX_W-1:0]            cfg_index_i,
  input  logic [ngfm_pkg::REG_W-1:0]            cfg_data_i,
  input  logic signed [ngfm_pkg::SAMPLE_WIDTH-1:0] sample_value_i,
  input  logic signed [ngfm_pkg::MIX_WIDTH-1:0] mix_in_i,
  input  logic                                  note_start_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [ngfm_pkg::MIX_WIDTH-1:0] mix_out_o,
  output logic [ngfm_pkg::FRAME_W-1:0]          frame_index_o,
  output logic                                  in_decay_o
);

  localparam int SW = ngfm_pkg::SAMPLE_WIDTH;
  localparam int MW = ngfm_pkg::MIX_WIDTH;
  localparam int RW = ngfm_pkg::REG_W;
  localparam int DW = ngfm_pkg::DLEN_W;
  localparam int QW = ngfm_pkg::QUO_W;
  localparam int PW = ngfm_pkg::PROD_W;
  localparam int XW = ngfm_pkg::SCALED_W;
  localparam int UW = ngfm_pkg::SUM_W;
  localparam int FB = ngfm_pkg::FRAC_BITS;

  // config and control state
  logic [RW-1:0]                  offset_q, length_q, cnt_q;
  logic [ngfm_pkg::GAIN_W-1:0]    gain_q;
  logic                           out_valid_q;

  // per word working registers
  logic [RW-1:0]                  i_q;
  logic [SW-1:0]                  mag_q;
  logic                           neg_q;
  logic signed [MW-1:0]           mix_q;
  logic [PW-1:0]                  p_q;
  logic [ngfm_pkg::START_PROD_W-1:0] start_prod_q;
  logic [DW-1:0]                  factor_q, dlen_q;
  logic                           decay_q;
  logic [DW-1:0]                  rem_q;
  logic [QW-1:0]                  quo_q;
  logic signed [MW-1:0]           mix_out_q;
  logic [ngfm_pkg::FRAME_W-1:0]   frame_q;
  logic                           in_decay_q;

  logic [RW-1:0]                  i_d;
  logic [SW-1:0]                  neg_s;
  logic [SW-1:0]                  mag_d;
  logic [ngfm_pkg::GAIN_W-1:0]    g_eff;
  logic [ngfm_pkg::LEN17_W-1:0]   len17;
  logic [ngfm_pkg::V_W-1:0]       v;
  logic [ngfm_pkg::START_PROD_W-1:0] start_prod_d;
  logic [RW-1:0]                  start;
  logic [RW-1:0]                  dlen_full, factor_full;
  logic                           past, decay;
  logic [PW-1:0]                  p_d;
  logic [XW-1:0]                  scaled;
  logic [DW:0]                    shifted, diff;
  logic                           ge;
  logic [QW-1:0]                  mag_term;
  logic [UW-1:0]                  term_u;
  logic signed [UW-1:0]           term_s, mix_ext, sum, sat_hi, sat_lo;
  logic signed [MW-1:0]           sat_sum;

  always_comb begin
    i_d   = note_start_i ? '0 : cnt_q;
    neg_s = -sample_value_i;
    mag_d = sample_value_i[SW-1] ? neg_s : sample_value_i;
    g_eff = (gain_q == '0) ? ngfm_pkg::UNITY_GAIN : gain_q;

    len17        = {length_q, 4'b0000} + ngfm_pkg::LEN17_W'(length_q);
    v            = len17[ngfm_pkg::LEN17_W-1:2];
    start_prod_d = ngfm_pkg::START_PROD_W'(v) * ngfm_pkg::START_PROD_W'(ngfm_pkg::RECIP_5);
    start        = start_prod_q[ngfm_pkg::RECIP_SHIFT +: RW];

    dlen_full   = length_q - start;
    factor_full = length_q - i_q - 1'b1;
    past        = (length_q != '0) && (i_q >= length_q);
    decay       = (length_q != '0) && (i_q >= start) && !past;

    p_d    = PW'(mag_q) * PW'(g_eff);
    scaled = XW'(p_q) * XW'(factor_q);

    shifted = {rem_q, quo_q[QW-1]};
    diff    = shifted - {1'b0, dlen_q};
    ge      = (shifted >= {1'b0, dlen_q});

    mag_term = decay_q ? quo_q : p_q[PW-1:FB];
    term_u   = UW'(mag_term);
    term_s   = neg_q ? -signed'(term_u) : signed'(term_u);
    mix_ext  = UW'(mix_q);
    sum      = mix_ext + term_s;
    sat_hi   = signed'(UW'({1'b0, {(MW-1){1'b1}}}));
    sat_lo   = ~sat_hi;
    if (sum > sat_hi) begin
      sat_sum = sat_hi[MW-1:0];
    end else if (sum < sat_lo) begin
      sat_sum = sat_lo[MW-1:0];
    end else begin
      sat_sum = sum[MW-1:0];
    end

    status_o.past     = past;
    status_o.decay    = decay;
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      length_q    <= '0;
      gain_q      <= ngfm_pkg::UNITY_GAIN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ngfm_pkg::REG_NOTE_OFFSET: offset_q <= cfg_data_i;
          ngfm_pkg::REG_NOTE_LENGTH: length_q <= cfg_data_i;
          ngfm_pkg::REG_GAIN:        gain_q   <= cfg_data_i[ngfm_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        cnt_q <= (i_d == '1) ? i_d : i_d + 1'b1;
      end
      if (cmd_i.write_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      i_q   <= i_d;
      mag_q <= mag_d;
      neg_q <= sample_value_i[SW-1];
      mix_q <= mix_in_i;
    end
    if (cmd_i.mul) begin
      p_q          <= p_d;
      start_prod_q <= start_prod_d;
    end
    if (cmd_i.eval) begin
      decay_q  <= decay;
      factor_q <= factor_full[DW-1:0];
      dlen_q   <= dlen_full[DW-1:0];
    end
    if (cmd_i.scale) begin
      rem_q <= scaled[XW-1 -: DW];
      quo_q <= scaled[FB +: QW];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
    if (cmd_i.write_out) begin
      mix_out_q  <= sat_sum;
      frame_q    <= ngfm_pkg::FRAME_W'(offset_q) + ngfm_pkg::FRAME_W'(i_q);
      in_decay_q <= decay_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mix_out_o     = mix_out_q;
  assign frame_index_o = frame_q;
  assign in_decay_o    = in_decay_q;

endmodule

FILE: design/note_gain_fade_mixer_unit.sv
// note gain fade mixer top level: one word at a time; full-gain words pass through multiply,
// evaluate and sum, fade words also through scale and the serial divider (one quotient bit
// per cycle), and words past the note give none and free the input after evaluate.
// a word waits in sum while the output is held; the output register lets the next
// word in while a result waits. async active-low reset clears state, counter and
// registers to defaults (gain unity); uses ngfm_pkg, ngfm_ctrl, ngfm_dp
module note_gain_fade_mixer_unit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [ngfm_pkg::IDX_W-1:0]               cfg_index_i,
  input  logic [ngfm_pkg::REG_W-1:0]               cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [ngfm_pkg::SAMPLE_WIDTH-1:0] sample_value_i,
  input  logic signed [ngfm_pkg::MIX_WIDTH-1:0]    mix_in_i,
  input  logic                                     note_start_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [ngfm_pkg::MIX_WIDTH-1:0]    mix_out_o,
  output logic [ngfm_pkg::FRAME_W-1:0]             frame_index_o,
  output logic                                     in_decay_o
);

  ngfm_pkg::cmd_t    cmd;
  ngfm_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  ngfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  ngfm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_value_i (sample_value_i),
    .mix_in_i       (mix_in_i),
    .note_start_i   (note_start_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .mix_out_o      (mix_out_o),
    .frame_index_o  (frame_index_o),
    .in_decay_o     (in_decay_o)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready while a word is in progress");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_out |-> !out_valid_o || out_ready_i)
    else $error("pending result overwritten");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_out |=> out_valid_o)
    else $error("written result not presented");
`endif

endmodule

FILE: bench/note_gain_fade_mixer_unit_tb.sv
// self-checking bench for note_gain_fade_mixer_unit: drives words and register writes,
// predicts gain, fade, saturation and frame index, and checks every result word
// depends on ngfm_pkg and the note_gain_fade_mixer_unit rtl
`timescale 1ns / 1ps

module note_gain_fade_mixer_unit_tb;

  localparam logic [ngfm_pkg::IDX_W-1:0] REG_SPARE = ngfm_pkg::IDX_W'(3);
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;
  localparam longint MIX_MAX   = (64'sd1 <<< (ngfm_pkg::MIX_WIDTH - 1)) - 1;
  localparam longint MIX_MIN   = -MIX_MAX - 1;

  typedef struct {
    logic signed [ngfm_pkg::MIX_WIDTH-1:0] mix;
    logic [ngfm_pkg::FRAME_W-1:0]          frame;
    logic                                  decay;
  } mix_result_t;

  class mix_scoreboard;
    logic [ngfm_pkg::REG_W-1:0]  note_offset;
    logic [ngfm_pkg::REG_W-1:0]  note_length;
    logic [ngfm_pkg::GAIN_W-1:0] gain;
    logic [ngfm_pkg::REG_W-1:0]  sample_count;
    mix_result_t                 expected_q[$];
    int                          errors;
    int                          n_results;
    int                          n_fade;

    function new();
      note_offset  = '0;
      note_length  = '0;
      gain         = ngfm_pkg::UNITY_GAIN;
      sample_count = '0;
      errors       = 0;
      n_results    = 0;
      n_fade       = 0;
    endfunction

    function void write_reg(logic [ngfm_pkg::IDX_W-1:0] idx,
                            logic [ngfm_pkg::REG_W-1:0] data);
      case (idx)
        ngfm_pkg::REG_NOTE_OFFSET: note_offset = data;
        ngfm_pkg::REG_NOTE_LENGTH: note_length = data;
        ngfm_pkg::REG_GAIN:        gain = data[ngfm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(logic signed [ngfm_pkg::SAMPLE_WIDTH-1:0] smp,
                            logic signed [ngfm_pkg::MIX_WIDTH-1:0] mix, logic start);
      longint      s_l, m_l, g, term, sum, dstart, dlen, factor, idx;
      mix_result_t r;
      if (start) sample_count = '0;
      idx = sample_count;
      if (sample_count != {ngfm_pkg::REG_W{1'b1}}) sample_count = sample_count + 1'b1;
      s_l = smp;
      m_l = mix;
      g = (gain == '0) ? longint'(ngfm_pkg::UNITY_GAIN) : longint'(gain);
      dstart = (longint'(note_length) * 85) / 100;
      dlen = longint'(note_length) - dstart;
      r.decay = 1'b0;
      if (note_length == '0 || idx < dstart) begin
        term = (s_l * g) / 4096;
      end else if (idx < longint'(note_length)) begin
        factor = dlen - (idx - dstart) - 1;
        term = (s_l * g * factor) / (4096 * dlen);
        r.decay = 1'b1;
        n_fade++;
      end else begin
        return;
      end
      sum = m_l + term;
      if (sum > MIX_MAX) sum = MIX_MAX;
      if (sum < MIX_MIN) sum = MIX_MIN;
      r.mix = sum[ngfm_pkg::MIX_WIDTH-1:0];
      r.frame = ngfm_pkg::FRAME_W'(longint'(note_offset) + idx);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [ngfm_pkg::MIX_WIDTH-1:0] mix,
                               logic [ngfm_pkg::FRAME_W-1:0] frame, logic decay);
      mix_result_t e;
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: mix_out %0d frame_index %0d", mix, frame);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (mix !== e.mix) begin
        $error("mix_out expected %0d got %0d", e.mix, mix);
        errors++;
      end
      if (frame !== e.frame) begin
        $error("frame_index expected %0d got %0d", e.frame, frame);
        errors++;
      end
      if (decay !== e.decay) begin
        $error("in_decay expected %0d got %0d", e.decay, decay);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report_leftover();
      if (expected_q.size() != 0) begin
        $error("%0d result words never arrived", expected_q.size());
        errors++;
      end
    endfunction
  endclass

  logic                                     clk_i = 1'b0;
  logic                                     rst_ni = 1'b0;
  logic                                     cfg_valid_i = 1'b0;
  logic                                     cfg_ready_o;
  logic [ngfm_pkg::IDX_W-1:0]               cfg_index_i = '0;
  logic [ngfm_pkg::REG_W-1:0]               cfg_data_i = '0;
  logic                                     in_valid_i = 1'b0;
  logic                                     in_ready_o;
  logic signed [ngfm_pkg::SAMPLE_WIDTH-1:0] sample_value_i = '0;
  logic signed [ngfm_pkg::MIX_WIDTH-1:0]    mix_in_i = '0;
  logic                                     note_start_i = 1'b0;
  logic                                     out_valid_o;
  logic                                     out_ready_i = 1'b0;
  logic signed [ngfm_pkg::MIX_WIDTH-1:0]    mix_out_o;
  logic [ngfm_pkg::FRAME_W-1:0]             frame_index_o;
  logic                                     in_decay_o;

  mix_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_active = 1'b0;
  int  cycle_count = 0;
  int  n_words = 0;
  int  n_writes = 0;
  event hold_ev;

  note_gain_fade_mixer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_value_i(sample_value_i),
    .mix_in_i      (mix_in_i),
    .note_start_i  (note_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mix_out_o     (mix_out_o),
    .frame_index_o (frame_index_o),
    .in_decay_o    (in_decay_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  always begin
    @(hold_ev);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(mix_out_o, frame_index_o, in_decay_o);
    end
  end

  function automatic logic signed [ngfm_pkg::SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(7))
      0: return {1'b0, {(ngfm_pkg::SAMPLE_WIDTH-1){1'b1}}};
      1: return {1'b1, {(ngfm_pkg::SAMPLE_WIDTH-1){1'b0}}};
      default: return ngfm_pkg::SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic signed [ngfm_pkg::MIX_WIDTH-1:0] pick_mix();
    case ($urandom_range(7))
      0: return ngfm_pkg::MIX_WIDTH'(MIX_MAX);
      1: return ngfm_pkg::MIX_WIDTH'(MIX_MIN);
      2: return ngfm_pkg::MIX_WIDTH'(MIX_MAX - $urandom_range(40000));
      3: return ngfm_pkg::MIX_WIDTH'(MIX_MIN + $urandom_range(40000));
      default: return ngfm_pkg::MIX_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_word(logic signed [ngfm_pkg::SAMPLE_WIDTH-1:0] smp,
                           logic signed [ngfm_pkg::MIX_WIDTH-1:0] mix, logic start);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= smp;
    mix_in_i       <= mix;
    note_start_i   <= start;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(smp, mix, start);
    n_words++;
  endtask

  task automatic write_reg(logic [ngfm_pkg::IDX_W-1:0] idx,
                           logic [ngfm_pkg::REG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    n_writes++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [ngfm_pkg::REG_W-1:0] offset,
                           logic [ngfm_pkg::REG_W-1:0] length,
                           logic [ngfm_pkg::REG_W-1:0] gain_data, bit touch_spare);
    settle();
    if (touch_spare) write_reg(REG_SPARE, ngfm_pkg::REG_W'($urandom));
    write_reg(ngfm_pkg::REG_NOTE_OFFSET, offset);
    write_reg(ngfm_pkg::REG_NOTE_LENGTH, length);
    write_reg(ngfm_pkg::REG_GAIN, gain_data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_note(int unsigned words);
    send_word(pick_sample(), pick_mix(), 1'b1);
    for (int unsigned j = 1; j < words; j++) send_word(pick_sample(), pick_mix(), 1'b0);
  endtask

  initial begin
    int unsigned len, count, words;
    logic [ngfm_pkg::REG_W-1:0] offset, length, gdata;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: no note length, unity gain, saturation both ways
    send_word(16'sh7fff, ngfm_pkg::MIX_WIDTH'(MIX_MAX), 1'b1);
    send_word(16'sh8000, ngfm_pkg::MIX_WIDTH'(MIX_MIN), 1'b0);
    send_word('0, '0, 1'b0);
    send_word(-16'sd1, 24'sd5, 1'b0);

    configure({ngfm_pkg::REG_W{1'b1}}, '0, 24'hab_ffff, 1'b1);
    send_word(16'sh8000, '0, 1'b1);
    send_word(16'sh7fff, ngfm_pkg::MIX_WIDTH'(MIX_MIN), 1'b0);
    send_word(-16'sd3, '0, 1'b0);

    // one-sample note: fade at factor zero, then past the note
    configure('0, 24'd1, '0, 1'b0);
    send_word(16'sd12345, '0, 1'b1);
    send_word(16'sd1, 24'sd1, 1'b0);
    send_word(16'sh7fff, '0, 1'b1);

    configure(24'd100, 24'd7, 24'd4096, 1'b0);
    send_word(16'sd20000, 24'sd10, 1'b1);
    for (int j = 0; j < 8; j++) send_word(pick_sample(), pick_mix(), 1'b0);

    for (int ph = 0; ph < 14; ph++) begin
      if (ph < 5) begin
        send_idle_pct = 27;
        recv_idle_pct = 88;
      end else if (ph < 10) begin
        send_idle_pct = 88;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: length = {ngfm_pkg::REG_W{1'b1}};
        1: length = '0;
        2: length = 24'd1;
        3: length = 24'd2;
        default: length = ($urandom_range(7) == 0) ? ngfm_pkg::REG_W'($urandom) :
                                                     ngfm_pkg::REG_W'($urandom_range(3, 60));
      endcase
      case (ph % 5)
        0: gdata = '0;
        1: gdata = {8'($urandom), 16'hffff};
        2: gdata = 24'd1;
        default: gdata = ngfm_pkg::REG_W'($urandom);
      endcase
      case (ph % 3)
        0: offset = '0;
        1: offset = {ngfm_pkg::REG_W{1'b1}};
        default: offset = ngfm_pkg::REG_W'($urandom);
      endcase
      configure(offset, length, gdata, ph == 7);
      if (ph == 10) -> hold_ev;
      count = 0;
      while (count < 35) begin
        if ($urandom_range(9) < 8) begin
          len = length;
          words = (len == 0 || len > 60) ? $urandom_range(1, 30) : len + $urandom_range(3);
          send_note(words);
          count += words;
        end else begin
          words = $urandom_range(1, 5);
          for (int unsigned j = 0; j < words; j++) begin
            send_word(pick_sample(), pick_mix(), 1'($urandom));
          end
          count += words;
        end
      end
    end

    settle();
    sb.report_leftover();
    $display("sent %0d words and %0d register writes; checked %0d results, %0d in the fade",
             n_words, n_writes, sb.n_results, sb.n_fade);
    $display("settings spanned zero, one, two, short and full-scale note lengths and gains");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ngfm_pkg.sv
design/ngfm_ctrl.sv
design/ngfm_dp.sv
design/note_gain_fade_mixer_unit.sv
bench/note_gain_fade_mixer_unit_tb.sv
